// File: sv/pbg_pkg.sv
package pbg_pkg;

  // Fixed-point format and accumulator
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 48;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Field and counter widths
  localparam int TIDX_W   = 10;  // table_index field
  localparam int CH_W     = 11;  // channel_count register
  localparam int INNER_W  = 21;  // inner_size register
  localparam int KW       = INNER_W - 1;  // widest running index
  localparam int IDXCMP_W = INNER_W;      // room to compare any index against the depth

  localparam logic [CH_W-1:0]    MAX_CHANNELS = CH_W'(1024);
  localparam logic [INNER_W-1:0] MAX_INNER    = INNER_W'(1048576);

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = INNER_W;
  localparam logic [CFG_IW-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_INNER    = 2'd2;

  // index_mode codes
  localparam logic [1:0] MODE_SHARED = 2'd0;
  localparam logic [1:0] MODE_NCHW   = 2'd1;
  localparam logic [1:0] MODE_NHWC   = 2'd2;
  localparam logic [1:0] MODE_ELEM   = 2'd3;

  // Accumulator epoch tags; tag zero never matches a live epoch
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_PW + 1;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_DATA  = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef struct packed {
    logic [KW-1:0] k;
    logic          err;
  } idx_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [ACC_W-1:0]   data;
  } acc_entry_t;

endpackage

// File: sv/prelu_backward_grad_top.sv
// Channel  Handshake                 Payload
// -------  ------------------------  ------------------------------------------------
// in       in_valid_i / in_stall_o   func_i, table_index_i, alpha_value_i,
//                                    x_value_i, dy_value_i
// out      out_valid_o / out_stall_i dx_value_o, alpha_grad_sum_o, index_error_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle in and out while neither side stalls. Each result
// passes read issue, multiply, then accumulate/round into the queue, and
// shows on out_valid_o once it is queued.
// A four-entry output queue with credit counting keeps the input open while
// results wait; in_stall_o rises only when four results are owed or the tag sweep runs.
// After reset, and on every 255th start-tensor command, a clearing pass over
// all TABLE_DEPTH entries (after a start, once the pipeline has emptied)
// rewrites the accumulator tags while in_stall_o is held high; config writes
// are taken throughout.
module prelu_backward_grad_top import pbg_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [TIDX_W-1:0]            table_index_i,
  input  logic signed [DATA_WIDTH-1:0] alpha_value_i,
  input  logic signed [DATA_WIDTH-1:0] x_value_i,
  input  logic signed [DATA_WIDTH-1:0] dy_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] dx_value_o,
  output logic signed [ACC_W-1:0]      alpha_grad_sum_o,
  output logic                         index_error_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IW-1:0]            cfg_index_i,
  input  logic [CFG_DW-1:0]            cfg_data_i
);

  logic take;
  logic busy;
  logic oq_full;
  idx_t idx;

  // result leaving the last pipeline stage
  logic                         res_valid;
  logic signed [DATA_WIDTH-1:0] res_dx;
  logic signed [ACC_W-1:0]      res_sum;
  logic                         res_err;

  // registers are plain flops; writes never need to wait
  assign cfg_ready_o = 1'b1;

  // input is held off while the queue has no credit or the tag sweep runs
  assign in_stall_o = oq_full || busy;
  assign take       = in_valid_i && !in_stall_o;

  // config registers and running position counters -> table index k
  pbg_index #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (take),
    .func_i      (func_e'(func_i)),
    .idx_o       (idx)
  );

  // alpha and accumulator memories with the read-modify-write pipeline
  pbg_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .func_i        (func_e'(func_i)),
    .table_index_i (table_index_i),
    .alpha_value_i (alpha_value_i),
    .x_value_i     (x_value_i),
    .dy_value_i    (dy_value_i),
    .idx_i         (idx),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_dx_o      (res_dx),
    .res_sum_o     (res_sum),
    .res_err_o     (res_err)
  );

  // output queue decouples the result side from the pipeline
  pbg_outq #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .push_i      (res_valid),
    .dx_i        (res_dx),
    .sum_i       (res_sum),
    .err_i       (res_err),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .dx_o        (dx_value_o),
    .sum_o       (alpha_grad_sum_o),
    .err_o       (index_error_o),
    .full_o      (oq_full)
  );

endmodule

// File: sv/pbg_index.sv
module pbg_index import pbg_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              step_i,
  input  func_e             func_i,
  output idx_t              idx_o
);

  logic [1:0]          mode_q;
  logic [CH_W-1:0]     chan_cnt_q;
  logic [INNER_W-1:0]  inner_size_q;
  logic [KW-1:0]       inner_q, inner_d;
  logic [CH_W-2:0]     chan_q, chan_d;

  logic [CH_W-1:0]     ch_lim;
  logic [INNER_W-1:0]  in_lim;
  logic [INNER_W-1:0]  inner_inc;
  logic [CH_W-1:0]     chan_inc;
  logic                inner_wrap, chan_wrap;
  logic [KW-1:0]       k;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_SHARED;
      chan_cnt_q   <= CH_W'(1);
      inner_size_q <= INNER_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:     mode_q       <= cfg_data_i[1:0];
        REG_CHANNELS: chan_cnt_q   <= cfg_data_i[CH_W-1:0];
        REG_INNER:    inner_size_q <= cfg_data_i[INNER_W-1:0];
        default:      ;
      endcase
    end
  end

  // limits clamped to their legal ranges
  always_comb begin
    if (chan_cnt_q == '0) begin
      ch_lim = CH_W'(1);
    end else if (chan_cnt_q > MAX_CHANNELS) begin
      ch_lim = MAX_CHANNELS;
    end else begin
      ch_lim = chan_cnt_q;
    end
    if (inner_size_q == '0) begin
      in_lim = INNER_W'(1);
    end else if (inner_size_q > MAX_INNER) begin
      in_lim = MAX_INNER;
    end else begin
      in_lim = inner_size_q;
    end
  end

  assign inner_inc  = {1'b0, inner_q} + INNER_W'(1);
  assign chan_inc   = {1'b0, chan_q} + CH_W'(1);
  assign inner_wrap = inner_inc >= in_lim;
  assign chan_wrap  = chan_inc >= ch_lim;

  always_comb begin
    inner_d = inner_q;
    chan_d  = chan_q;
    if (step_i && (func_i == FN_START)) begin
      inner_d = '0;
      chan_d  = '0;
    end else if (step_i && (func_i == FN_DATA)) begin
      unique case (mode_q)
        MODE_NCHW: begin
          if (inner_wrap) begin
            inner_d = '0;
            chan_d  = chan_wrap ? '0 : chan_inc[CH_W-2:0];
          end else begin
            inner_d = inner_inc[KW-1:0];
          end
        end
        MODE_NHWC: chan_d  = chan_wrap ? '0 : chan_inc[CH_W-2:0];
        MODE_ELEM: inner_d = inner_wrap ? '0 : inner_inc[KW-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      chan_q  <= '0;
    end else begin
      inner_q <= inner_d;
      chan_q  <= chan_d;
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_SHARED: k = '0;
      MODE_ELEM:   k = inner_q;
      default:     k = KW'(chan_q);
    endcase
  end

  assign idx_o.k   = k;
  assign idx_o.err = IDXCMP_W'(k) >= IDXCMP_W'(TABLE_DEPTH);

endmodule

// File: sv/pbg_core.sv
module pbg_core import pbg_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  func_e                        func_i,
  input  logic [TIDX_W-1:0]            table_index_i,
  input  logic signed [DATA_WIDTH-1:0] alpha_value_i,
  input  logic signed [DATA_WIDTH-1:0] x_value_i,
  input  logic signed [DATA_WIDTH-1:0] dy_value_i,
  input  idx_t                         idx_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output logic signed [DATA_WIDTH-1:0] res_dx_o,
  output logic signed [ACC_W-1:0]      res_sum_o,
  output logic                         res_err_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;
  localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic signed [RW-1:0] DMAX = RW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] DMIN = -DMAX - RW'(1);
  localparam logic signed [RW-1:0] RHALF = RW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] AMAX = SW'(ACC_MAX);
  localparam logic signed [SW-1:0] AMIN = SW'(ACC_MIN);

  localparam logic [1:0] SWP_IDLE = 2'd0;
  localparam logic [1:0] SWP_WAIT = 2'd1;
  localparam logic [1:0] SWP_RUN  = 2'd2;

  // memories
  logic signed [DW-1:0] alpha_mem [TABLE_DEPTH];
  acc_entry_t           acc_mem   [TABLE_DEPTH];
  logic signed [DW-1:0] alpha_rd_q;
  acc_entry_t           acc_rd_q;

  // control
  logic [1:0]         swp_q, swp_d;
  logic [AW-1:0]      swp_cnt_q, swp_cnt_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               b_valid_q, c_valid_q, w_valid_q;

  // stage A
  logic          tidx_oor, a_err, a_wrap;
  logic [AW-1:0] a_addr;
  logic          alpha_wr, alpha_rd, acc_rd;

  // stage B
  func_e                b_func_q;
  logic                 b_err_q;
  logic [AW-1:0]        b_addr_q;
  logic signed [DW-1:0] b_x_q, b_dy_q;
  logic [EPOCH_W-1:0]   b_epoch_q;
  logic                 b_xpos;
  acc_entry_t           b_ent;
  logic signed [ACC_W-1:0] b_base;
  logic signed [PW-1:0] b_prod_a, b_prod_x;

  // stage C
  func_e                   c_func_q;
  logic                    c_err_q, c_xpos_q;
  logic [AW-1:0]           c_addr_q;
  logic [EPOCH_W-1:0]      c_epoch_q;
  logic signed [DW-1:0]    c_dy_q;
  logic signed [ACC_W-1:0] c_base_q;
  logic signed [PW-1:0]    c_prod_a_q, c_prod_x_q;
  logic signed [SW-1:0]    c_sum;
  logic signed [ACC_W-1:0] c_sum_sat;
  logic signed [RW-1:0]    c_rnd, c_shr;
  logic signed [DW-1:0]    c_dx_sat;
  logic                    c_wr;

  // last write, for the read that raced it
  logic [AW-1:0] w_addr_q;
  acc_entry_t    w_ent_q;

  // accumulator write port
  logic          acc_we;
  logic [AW-1:0] acc_waddr;
  acc_entry_t    acc_wdata;

  // ---------------- stage A: decode, issue reads ----------------
  assign tidx_oor = IDXCMP_W'(table_index_i) >= IDXCMP_W'(TABLE_DEPTH);

  always_comb begin
    unique case (func_i)
      FN_LOAD, FN_READ: a_err = tidx_oor;
      FN_DATA:          a_err = idx_i.err;
      default:          a_err = 1'b0;
    endcase
  end

  assign a_addr   = (func_i == FN_DATA) ? AW'(idx_i.k) : AW'(table_index_i);
  assign alpha_wr = take_i && (func_i == FN_LOAD) && !tidx_oor;
  assign alpha_rd = take_i && (func_i == FN_DATA) && !idx_i.err;
  assign acc_rd   = take_i && ((func_i == FN_DATA) || (func_i == FN_READ)) && !a_err;
  assign a_wrap   = epoch_q == EPOCH_MAX;

  always_ff @(posedge clk_i) begin
    if (alpha_wr) begin
      alpha_mem[a_addr] <= alpha_value_i;
    end
    if (alpha_rd) begin
      alpha_rd_q <= alpha_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_rd) begin
      acc_rd_q <= acc_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      b_func_q  <= func_i;
      b_err_q   <= a_err;
      b_addr_q  <= a_addr;
      b_x_q     <= x_value_i;
      b_dy_q    <= dy_value_i;
      b_epoch_q <= epoch_q;
    end
  end

  // ---------------- stage B: forward, multiply ----------------
  assign b_xpos = !b_x_q[DW-1] && (b_x_q != '0);

  always_comb begin
    priority if (c_wr && (c_addr_q == b_addr_q)) begin
      b_ent = '{tag: c_epoch_q, data: c_sum_sat};
    end else if (w_valid_q && (w_addr_q == b_addr_q)) begin
      b_ent = w_ent_q;
    end else begin
      b_ent = acc_rd_q;
    end
  end

  // an entry tagged with another epoch was not touched since tensor start
  assign b_base   = (b_ent.tag == b_epoch_q) ? signed'(b_ent.data) : '0;
  assign b_prod_a = alpha_rd_q * b_dy_q;
  assign b_prod_x = b_x_q * b_dy_q;

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      c_func_q   <= b_func_q;
      c_err_q    <= b_err_q;
      c_xpos_q   <= b_xpos;
      c_addr_q   <= b_addr_q;
      c_epoch_q  <= b_epoch_q;
      c_dy_q     <= b_dy_q;
      c_base_q   <= b_base;
      c_prod_a_q <= b_prod_a;
      c_prod_x_q <= b_prod_x;
    end
  end

  // ---------------- stage C: accumulate, round, write back ----------------
  assign c_sum = SW'(c_base_q) + SW'(c_prod_x_q);

  always_comb begin
    if (c_sum > AMAX) begin
      c_sum_sat = ACC_MAX;
    end else if (c_sum < AMIN) begin
      c_sum_sat = ACC_MIN;
    end else begin
      c_sum_sat = c_sum[ACC_W-1:0];
    end
  end

  // round half up, then clip to the data width
  assign c_rnd = RW'(c_prod_a_q) + RHALF;
  assign c_shr = c_rnd >>> FRAC_BITS;

  always_comb begin
    if (c_shr > DMAX) begin
      c_dx_sat = DMAX[DW-1:0];
    end else if (c_shr < DMIN) begin
      c_dx_sat = DMIN[DW-1:0];
    end else begin
      c_dx_sat = c_shr[DW-1:0];
    end
  end

  assign c_wr = c_valid_q && (c_func_q == FN_DATA) && !c_err_q && !c_xpos_q;

  always_comb begin
    if (swp_q == SWP_RUN) begin
      acc_we    = 1'b1;
      acc_waddr = swp_cnt_q;
      acc_wdata = '0;
    end else begin
      acc_we    = c_wr;
      acc_waddr = c_addr_q;
      acc_wdata = '{tag: c_epoch_q, data: c_sum_sat};
    end
  end

  always_ff @(posedge clk_i) begin
    w_addr_q <= c_addr_q;
    w_ent_q  <= '{tag: c_epoch_q, data: c_sum_sat};
  end

  always_comb begin
    priority if (c_func_q != FN_DATA) begin
      res_dx_o = '0;
    end else if (c_xpos_q) begin
      res_dx_o = c_dy_q;
    end else if (c_err_q) begin
      res_dx_o = '0;
    end else begin
      res_dx_o = c_dx_sat;
    end
  end

  assign res_sum_o   = ((c_func_q == FN_READ) && !c_err_q) ? c_base_q : '0;
  assign res_err_o   = c_err_q;
  assign res_valid_o = c_valid_q;

  // ---------------- epoch and clearing sweep ----------------
  always_comb begin
    epoch_d   = epoch_q;
    swp_d     = swp_q;
    swp_cnt_d = swp_cnt_q;
    if (take_i && (func_i == FN_START)) begin
      epoch_d = a_wrap ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
    end
    unique case (swp_q)
      SWP_IDLE: begin
        if (take_i && (func_i == FN_START) && a_wrap) begin
          swp_d = SWP_WAIT;
        end
      end
      SWP_WAIT: begin
        if (!b_valid_q && !c_valid_q) begin
          swp_d     = SWP_RUN;
          swp_cnt_d = '0;
        end
      end
      SWP_RUN: begin
        swp_cnt_d = swp_cnt_q + AW'(1);
        if (swp_cnt_q == LAST_ADDR) begin
          swp_d = SWP_IDLE;
        end
      end
      default: swp_d = SWP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_q     <= SWP_RUN;
      swp_cnt_q <= '0;
      epoch_q   <= EPOCH_FIRST;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
    end else begin
      swp_q     <= swp_d;
      swp_cnt_q <= swp_cnt_d;
      epoch_q   <= epoch_d;
      b_valid_q <= take_i;
      c_valid_q <= b_valid_q;
      w_valid_q <= c_wr;
    end
  end

  assign busy_o = swp_q != SWP_IDLE;

endmodule

// File: sv/pbg_outq.sv
module pbg_outq import pbg_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic                         push_i,
  input  logic signed [DATA_WIDTH-1:0] dx_i,
  input  logic signed [ACC_W-1:0]      sum_i,
  input  logic                         err_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] dx_o,
  output logic signed [ACC_W-1:0]      sum_o,
  output logic                         err_o,
  output logic                         full_o
);

  logic signed [DATA_WIDTH-1:0] dx_mem  [OQ_DEPTH];
  logic signed [ACC_W-1:0]      sum_mem [OQ_DEPTH];
  logic                         err_mem [OQ_DEPTH];

  logic [OQ_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CW-1:0] fill_q, credit_q;
  logic             pop;

  assign out_valid_o = fill_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  // credits cover results still in the pipeline as well as queued ones
  assign full_o      = credit_q == OQ_CW'(OQ_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      dx_mem[wr_ptr_q]  <= dx_i;
      sum_mem[wr_ptr_q] <= sum_i;
      err_mem[wr_ptr_q] <= err_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OQ_PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OQ_PW'(1);
      end
      fill_q   <= fill_q + OQ_CW'(push_i) - OQ_CW'(pop);
      credit_q <= credit_q + OQ_CW'(take_i) - OQ_CW'(pop);
    end
  end

  assign dx_o  = dx_mem[rd_ptr_q];
  assign sum_o = sum_mem[rd_ptr_q];
  assign err_o = err_mem[rd_ptr_q];

endmodule

// File: sim/testbench.sv
module testbench import pbg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int DW    = 16;

  // Quiet cycles allowed before the run is declared hung. The longest legal
  // quiet stretches are the tag-clearing pass and the receiver hold-off of
  // test_output_holdoff, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4 * DEPTH;
  // Pipeline stages A, B and C feed a four-entry output queue.
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 360;
  localparam int ALPHA_LOADED   = 16;   // alpha entries 0 .. ALPHA_LOADED-1

  localparam longint DX_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint DX_MIN = -DX_MAX - 1;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  func_e                in_func   = FN_LOAD;
  logic [TIDX_W-1:0]    in_tidx   = '0;
  logic signed [DW-1:0] in_alpha  = '0;
  logic signed [DW-1:0] in_x      = '0;
  logic signed [DW-1:0] in_dy     = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_dx;
  logic signed [ACC_W-1:0] out_gsum;
  logic                 out_err;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index = REG_MODE;
  logic [CFG_DW-1:0]    cfg_data  = '0;

  prelu_backward_grad_top #(
    .TABLE_DEPTH (DEPTH),
    .DATA_WIDTH  (DW)
  ) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (in_func),
    .table_index_i    (in_tidx),
    .alpha_value_i    (in_alpha),
    .x_value_i        (in_x),
    .dy_value_i       (in_dy),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .dx_value_o       (out_dx),
    .alpha_grad_sum_o (out_gsum),
    .index_error_o    (out_err),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // 12 ns period, first edge rising
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Gradient predictor: shadow copy of the alpha table, the accumulators and
  // the position counters, plus the three config registers.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic signed [DW-1:0]    dx;
    logic signed [ACC_W-1:0] grad;
    logic                    err;
  } grad_result_t;

  grad_result_t         pending_grads[$];   // expected results, oldest first

  logic signed [DW-1:0] alpha_mem [DEPTH];
  bit                   alpha_set [DEPTH];  // alpha entry loaded at least once
  longint               grad_mem  [DEPTH];
  bit                   grad_live [DEPTH];  // accumulator touched since tensor start
  int unsigned          inner_pos = 0;
  int unsigned          chan_pos  = 0;
  logic [1:0]           mode_reg  = MODE_SHARED;
  int unsigned          chan_reg  = 1;
  int unsigned          inner_reg = 1;

  int  err_count   = 0;
  int  items_sent  = 0;
  bit  idling      = 1'b1;  // random gaps on both channels
  int  hold_cycles = 0;     // request for a long receiver hold-off

  // table entry the next data element will use
  function automatic int unsigned next_k();
    if (mode_reg == MODE_SHARED) return 0;
    else if (mode_reg == MODE_ELEM) return inner_pos;
    else return chan_pos;
  endfunction

  function automatic grad_result_t predict_grads(input func_e fn,
                                                 input logic [TIDX_W-1:0] tidx,
                                                 input logic signed [DW-1:0] alpha, x, dy);
    grad_result_t r;
    int unsigned  ch_lim, in_lim, k;
    longint       prod, sum;
    r.dx   = '0;
    r.grad = '0;
    r.err  = 1'b0;
    case (fn)
      FN_LOAD: begin
        if (tidx < DEPTH) begin
          alpha_mem[tidx] = alpha;
          alpha_set[tidx] = 1'b1;
        end else r.err = 1'b1;
      end
      FN_START: begin
        foreach (grad_live[i]) grad_live[i] = 1'b0;
        inner_pos = 0;
        chan_pos  = 0;
      end
      FN_DATA: begin
        // registers are clamped to their legal ranges at use
        ch_lim = (chan_reg < 1) ? 1 : ((chan_reg > 1024) ? 1024 : chan_reg);
        in_lim = (inner_reg < 1) ? 1 : ((inner_reg > 1048576) ? 1048576 : inner_reg);
        k = next_k();
        r.err = (k >= DEPTH);
        if (x > 0) begin
          r.dx = dy;
        end else if (!r.err) begin
          // alpha*dy has 24 fraction bits; round half up back to 12, saturate
          prod = longint'(alpha_mem[k]) * longint'(dy);
          prod = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          if (prod > DX_MAX) prod = DX_MAX;
          if (prod < DX_MIN) prod = DX_MIN;
          r.dx = DW'(prod);
          sum = (grad_live[k] ? grad_mem[k] : 0) + longint'(x) * longint'(dy);
          if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
          if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
          grad_mem[k]  = sum;
          grad_live[k] = 1'b1;
        end
        case (mode_reg)
          MODE_NCHW: begin
            inner_pos++;
            if (inner_pos >= in_lim) begin
              inner_pos = 0;
              chan_pos++;
              if (chan_pos >= ch_lim) chan_pos = 0;
            end
          end
          MODE_NHWC: begin
            chan_pos++;
            if (chan_pos >= ch_lim) chan_pos = 0;
          end
          MODE_ELEM: begin
            inner_pos++;
            if (inner_pos >= in_lim) inner_pos = 0;
          end
          default: ;
        endcase
      end
      FN_READ: begin
        if (tidx < DEPTH) r.grad = grad_live[tidx] ? ACC_W'(grad_mem[tidx]) : '0;
        else r.err = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Q4.12 operand with extra weight on the corners and on tiny values
  function automatic logic signed [DW-1:0] rand_q12();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '0;
      3:       return DW'($urandom_range(0, 8)) - DW'(4);
      default: return DW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel: one transaction, with an optional random gap in front.
  // Inputs change on the falling edge; acceptance is seen on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input func_e fn, input logic [TIDX_W-1:0] tidx,
                           input logic signed [DW-1:0] alpha, x, dy);
    int gap;
    if (idling && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_func  = fn;
    in_tidx  = tidx;
    in_alpha = alpha;
    in_x     = x;
    in_dy    = dy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_grads.push_back(predict_grads(fn, tidx, alpha, x, dy));
    items_sent++;
  endtask

  // Fields a command does not use carry random junk
  task automatic load_alpha(input int idx, input logic signed [DW-1:0] value);
    send_item(FN_LOAD, TIDX_W'(idx), value, rand_q12(), rand_q12());
  endtask

  task automatic start_tensor();
    send_item(FN_START, TIDX_W'($urandom), rand_q12(), rand_q12(), rand_q12());
  endtask

  // An element that would read an alpha entry never loaded gets a positive x
  task automatic send_data(input logic signed [DW-1:0] x, dy);
    int unsigned          k;
    logic signed [DW-1:0] xs;
    k  = next_k();
    xs = x;
    if (k < DEPTH && !alpha_set[k] && xs <= 0) xs = DW'($urandom_range(1, 32767));
    send_item(FN_DATA, TIDX_W'($urandom), rand_q12(), xs, dy);
  endtask

  task automatic read_grad(input int idx);
    send_item(FN_READ, TIDX_W'(idx), rand_q12(), rand_q12(), rand_q12());
  endtask

  // Stop offering input and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IW-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:     mode_reg  = value[1:0];
      REG_CHANNELS: chan_reg  = value & 32'h7FF;
      REG_INNER:    inner_reg = value & 32'h1F_FFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers only change with the pipeline empty
  task automatic set_config(input logic [1:0] mode, input int unsigned chans,
                            input int unsigned inner);
    drain();
    write_cfg(REG_MODE, mode);
    write_cfg(REG_CHANNELS, chans);
    write_cfg(REG_INNER, inner);
  endtask

  // ---------------------------------------------------------------------------
  // Output channel: random stall bursts, or a long hold-off on request
  // ---------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      for (int n = 0; n < hold_cycles; n++) @(negedge clk);
      hold_cycles = 0;
      out_stall = 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 14)) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
    err_count++;
  endtask

  // Each accepted result against the oldest expectation, field by field
  always @(posedge clk) begin
    grad_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grads.size() == 0) begin
        $display("%0t: unexpected result: dx=%0d grad=%0d err=%0d",
                 $time, out_dx, out_gsum, out_err);
        err_count++;
      end else begin
        want = pending_grads.pop_front();
        if (out_dx !== want.dx) flag_mismatch("dx_value", want.dx, out_dx);
        if (out_gsum !== want.grad) flag_mismatch("alpha_grad_sum", want.grad, out_gsum);
        if (out_err !== want.err) flag_mismatch("index_error", want.err, out_err);
      end
    end
  end

  // Watchdog: cycles in which no channel completes a transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_grads.size());
      $display("** prelu_backward_grad_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load the low alpha entries and the last one, which walks every
  // table_index bit. Elements landing on other entries go the positive path.
  task automatic test_alpha_table();
    for (int i = 0; i < ALPHA_LOADED; i++) load_alpha(i, rand_q12());
    load_alpha(DEPTH - 1, rand_q12());
    drain();
  endtask

  // Reset register values, dx saturation both ways, x on the zero boundary,
  // half-up rounding, reads of live and untouched accumulators.
  task automatic test_directed();
    start_tensor();
    load_alpha(0, 16'sh8000);
    send_data(16'sh8000, 16'sh8000);   // dx clips high
    send_data(16'sh8000, 16'sh7FFF);   // dx clips low
    send_data(16'sh0000, 16'sd12345);  // x == 0 takes the alpha path
    send_data(16'sh0001, 16'sh8000);   // smallest positive x passes dy
    send_data(16'sh7FFF, 16'sh7FFF);
    load_alpha(0, 16'sh0001);
    send_data(-16'sd1, 16'sd2048);     // exactly half rounds up to 1
    send_data(-16'sd1, -16'sd2048);    // minus half rounds up to 0
    send_data(-16'sd1, -16'sd2049);
    send_data(-16'sd1, 16'sd6144);
    load_alpha(0, 16'sh7FFF);
    send_data(-16'sd5, 16'sh7FFF);
    load_alpha(DEPTH - 1, 16'sh1000);
    read_grad(0);
    read_grad(1);                      // never accumulated: reads zero
    read_grad(DEPTH - 1);
    start_tensor();
    read_grad(0);                      // cleared by the new tensor
    drain();
  endtask

  // Every mode with small, typical and out-of-range register values
  task automatic test_register_modes();
    logic [1:0]  modes  [10] = '{MODE_NCHW, MODE_NCHW, MODE_NCHW, MODE_NCHW, MODE_NHWC,
                                 MODE_NHWC, MODE_ELEM, MODE_ELEM, MODE_SHARED, MODE_NHWC};
    int unsigned chans  [10] = '{3, 1, 0, 2047, 5, 1024, 1, 2, 2047, 0};
    int unsigned inners [10] = '{4, 1, 0, 2, 3, 1, 7, 2097151, 2097151, 1048576};
    for (int s = 0; s < 10; s++) begin
      set_config(modes[s], chans[s], inners[s]);
      start_tensor();
      repeat (16) send_data(rand_q12(), rand_q12());
      for (int i = 0; i < 8; i++) read_grad(i);
      read_grad($urandom_range(0, DEPTH - 1));
    end
    drain();
  endtask

  // Register changes inside a tensor keep the counters; a counter already
  // past a shrunken limit wraps on its next step.
  task automatic test_mid_tensor();
    set_config(MODE_ELEM, 1, 10);
    start_tensor();
    repeat (7) send_data(rand_q12(), rand_q12());
    drain();
    write_cfg(REG_INNER, 4);
    repeat (5) send_data(rand_q12(), rand_q12());
    drain();
    write_cfg(REG_MODE, MODE_NCHW);
    write_cfg(REG_CHANNELS, 3);
    repeat (6) send_data(rand_q12(), rand_q12());
    drain();
    write_cfg(REG_MODE, MODE_NHWC);
    write_cfg(REG_CHANNELS, 2);
    repeat (4) send_data(rand_q12(), rand_q12());
    drain();
    write_cfg(REG_MODE, MODE_ELEM);
    repeat (3) send_data(rand_q12(), rand_q12());
    for (int i = 0; i < 10; i++) read_grad(i);
    drain();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input;
  // afterwards the sender waits for every result before going on.
  task automatic test_output_holdoff();
    idling = 1'b0;
    set_config(MODE_NHWC, 8, 1);
    start_tensor();
    hold_cycles = 300;
    repeat (40) send_data(rand_q12(), rand_q12());
    for (int i = 0; i < 8; i++) read_grad(i);
    drain();
    idling = 1'b1;
  endtask

  // Enough tensor starts to run into the periodic tag-clearing pass, sent
  // back to back; this is the last part of the run and has no idling.
  task automatic test_tensor_restarts();
    idling = 1'b0;
    set_config(MODE_SHARED, 1, 1);
    for (int n = 0; n < 256; n++) begin
      start_tensor();
      if (n % 16 == 0) begin
        read_grad(0);                  // untouched since the start: zero
        send_data(rand_q12(), rand_q12());
        read_grad(0);
      end
    end
    drain();
  endtask

  function automatic int unsigned pick_channels();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1024;
      2:       return 2047;
      3:       return $urandom_range(0, 2047);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_inner();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 2097151;
      2:       return 1048576;
      3:       return $urandom_range(0, 2097151);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Random tensors: mostly data elements with reads, alpha reloads and the odd
  // restart mixed in. Sometimes the registers change without a new tensor.
  task automatic test_random_tensors();
    int first;
    int len;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      idling = ($urandom_range(0, 4) != 0);
      set_config(2'($urandom_range(0, 3)), pick_channels(), pick_inner());
      if ($urandom_range(0, 3) != 0) start_tensor();
      len = $urandom_range(10, 60);
      repeat (len) begin
        case ($urandom_range(0, 19))
          15, 16:  read_grad($urandom_range(0, DEPTH - 1));
          17:      load_alpha($urandom_range(0, DEPTH - 1), rand_q12());
          18:      start_tensor();
          19:      read_grad($urandom_range(0, 15));
          default: send_data(rand_q12(), rand_q12());
        endcase
      end
    end
    drain();
    idling = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_alpha_table();
    test_directed();
    test_register_modes();
    test_mid_tensor();
    test_output_holdoff();
    test_random_tensors();
    test_tensor_restarts();  // last part runs without idling

    drain();
    if (pending_grads.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_grads.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("** prelu_backward_grad_top: PASSED **");
    end else begin
      $display("** prelu_backward_grad_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pbg_pkg.sv
sv/pbg_index.sv
sv/pbg_core.sv
sv/pbg_outq.sv
sv/prelu_backward_grad_top.sv
sim/testbench.sv
